>>> rtl/lspf_pkg.sv
// Package for the least squares polynomial fit: widths, codes, command structs, term tables.
`default_nettype none
package lspf_pkg;

  // Field and accumulator widths
  localparam int COORD_W = 12;
  localparam int CNT_W   = 13;
  localparam int SX_W    = 25;
  localparam int SX2_W   = 36;
  localparam int SX3_W   = 46;
  localparam int SX4_W   = 58;
  localparam int SY_W    = 25;
  localparam int SXY_W   = 36;
  localparam int SX2Y_W  = 46;
  localparam int COEF_W  = 48;
  localparam int DEG_W   = 2;

  // Multiplier operand width (widest sum) and wide solver word
  localparam int OPW = SX4_W;
  localparam int WB  = 160;

  localparam logic [WB-1:0] POS_LIM = WB'(48'h7FFF_FFFF_FFFF);
  localparam logic [WB-1:0] NEG_MAG = WB'(48'h8000_0000_0000);
  localparam logic [COEF_W-1:0] POS_COEF = 48'h7FFF_FFFF_FFFF;
  localparam logic [COEF_W-1:0] NEG_COEF = 48'h8000_0000_0000;

  localparam logic [DEG_W-1:0] DEG_LINE = 2'd1;

  // Operand selects; order matches matrix entry index arithmetic
  typedef enum logic [2:0] {
    OP_N, OP_SX, OP_SX2, OP_SX3, OP_SX4, OP_SY, OP_SXY, OP_SX2Y
  } op_sel_t;

  typedef enum logic [1:0] {
    COEF_QUAD, COEF_LIN, COEF_CONST
  } coef_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAIN0, ST_DRAIN1, ST_START, ST_LOADP, ST_MULA, ST_WAITA,
    ST_MULB, ST_WAITB, ST_ENDTERM, ST_DENCHK, ST_DIVGO, ST_DIVWAIT, ST_PUB
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE, DIV_PREP, DIV_ITER, DIV_FIN
  } div_state_t;

  typedef struct packed {
    logic      accept;
    logic      acc_clr;
    logic      coef_clr;
    logic      load_p;
    logic      mul_start;
    logic      mul_to_acc;
    logic      mul_neg;
    op_sel_t   op_sel;
    logic      save_den;
    logic      set_sing;
    logic      div_start;
    coef_sel_t coef_sel;
    logic      publish;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic acc_zero;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    op_sel_t f1;
    op_sel_t f2;
    op_sel_t f3;
    logic    neg;
    logic    three;
  } term_t;

  // Entry of the 3x3 normal matrix, column (ph-1) replaced by the right hand side
  function automatic op_sel_t mat_entry(input logic [1:0] r, input logic [1:0] c,
                                        input logic [1:0] ph);
    logic [2:0] idx;
    if ((ph != 2'd0) && (c == (ph - 2'd1))) begin
      idx = 3'd5 + {1'b0, r};
    end else begin
      idx = {1'b0, r} + {1'b0, c};
    end
    return op_sel_t'(idx);
  endfunction

  // One product term of a determinant: phase 0 is the denominator
  function automatic term_t term_info(input logic quad, input logic [1:0] ph,
                                      input logic [2:0] k);
    term_t t;
    logic [1:0] c0, c1, c2;
    t = '0;
    c0 = 2'd0;
    c1 = 2'd1;
    c2 = 2'd2;
    if (quad) begin
      case (k)
        3'd0: begin c0 = 2'd0; c1 = 2'd1; c2 = 2'd2; t.neg = 1'b0; end
        3'd1: begin c0 = 2'd0; c1 = 2'd2; c2 = 2'd1; t.neg = 1'b1; end
        3'd2: begin c0 = 2'd1; c1 = 2'd0; c2 = 2'd2; t.neg = 1'b1; end
        3'd3: begin c0 = 2'd1; c1 = 2'd2; c2 = 2'd0; t.neg = 1'b0; end
        3'd4: begin c0 = 2'd2; c1 = 2'd0; c2 = 2'd1; t.neg = 1'b0; end
        default: begin c0 = 2'd2; c1 = 2'd1; c2 = 2'd0; t.neg = 1'b1; end
      endcase
      t.f1 = mat_entry(2'd0, c0, ph);
      t.f2 = mat_entry(2'd1, c1, ph);
      t.f3 = mat_entry(2'd2, c2, ph);
      t.three = 1'b1;
    end else begin
      t.three = 1'b0;
      t.f3 = OP_N;
      t.neg = k[0];
      case (ph)
        2'd0: begin
          t.f1 = k[0] ? OP_SX : OP_SX2;
          t.f2 = k[0] ? OP_SX : OP_N;
        end
        2'd1: begin
          t.f1 = k[0] ? OP_SX : OP_SXY;
          t.f2 = k[0] ? OP_SY : OP_N;
        end
        default: begin
          t.f1 = k[0] ? OP_SX : OP_SX2;
          t.f2 = k[0] ? OP_SXY : OP_SY;
        end
      endcase
    end
    return t;
  endfunction

  // Which coefficient a numerator phase produces
  function automatic coef_sel_t coef_for(input logic quad, input logic [1:0] ph);
    coef_sel_t s;
    if (quad) begin
      case (ph)
        2'd1:    s = COEF_CONST;
        2'd2:    s = COEF_LIN;
        default: s = COEF_QUAD;
      endcase
    end else begin
      s = (ph == 2'd1) ? COEF_LIN : COEF_CONST;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lspf_dp.sv
// Datapath: point accumulation pipeline, serial multiplier, restoring divider, output register.
`default_nettype none
module lspf_dp #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire  logic                                clk,
  input  wire  logic                                rst_n,
  input  wire  logic signed [lspf_pkg::COORD_W-1:0] in_x_coord,
  input  wire  logic signed [lspf_pkg::COORD_W-1:0] in_y_coord,
  input  wire  lspf_pkg::dp_cmd_t                   cmd,
  output lspf_pkg::dp_stat_t                        stat,
  input  wire  logic                                out_stall,
  output logic                                      out_valid,
  output logic signed [lspf_pkg::COEF_W-1:0]        out_coef_quad,
  output logic signed [lspf_pkg::COEF_W-1:0]        out_coef_lin,
  output logic signed [lspf_pkg::COEF_W-1:0]        out_coef_const,
  output logic                                      out_singular,
  output logic                                      out_saturated,
  output logic [lspf_pkg::CNT_W-1:0]                out_points_used
);
  import lspf_pkg::*;

  localparam int SH = COORD_W - COORD_BITS;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_POINTS);
  localparam int MCNT_W = $clog2(OPW);
  localparam int DCNT_W = $clog2(WB);

  // Coordinates reduced to COORD_BITS and sign extended
  logic signed [COORD_W-1:0] xs, ys;
  assign xs = (in_x_coord <<< SH) >>> SH;
  assign ys = (in_y_coord <<< SH) >>> SH;

  // Pipeline stage payloads
  logic signed [COORD_W-1:0]   x1_r, y1_r;
  logic signed [2*COORD_W-1:0] x2_r, xy_r;
  logic signed [3*COORD_W-1:0] x3_r, x2y_r;
  logic signed [4*COORD_W-1:0] x4_r;
  logic take1_r, take2_r;

  logic [CNT_W-1:0]         cnt_r;
  logic                     ovf_r;
  logic signed [SX_W-1:0]   sx_r;
  logic signed [SX2_W-1:0]  sx2_r;
  logic signed [SX3_W-1:0]  sx3_r;
  logic signed [SX4_W-1:0]  sx4_r;
  logic signed [SY_W-1:0]   sy_r;
  logic signed [SXY_W-1:0]  sxy_r;
  logic signed [SX2Y_W-1:0] sx2y_r;

  always_ff @(posedge clk) begin
    x1_r  <= xs;
    y1_r  <= ys;
    x2_r  <= xs * xs;
    xy_r  <= xs * ys;
    x3_r  <= x2_r * x1_r;
    x4_r  <= x2_r * x2_r;
    x2y_r <= x2_r * y1_r;
  end

  // Accumulators: sums of x, y, x^2 and xy take the first pipeline stage, sums of x^3, x^4 and x^2*y the second
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ovf_r <= 1'b0; take1_r <= 1'b0; take2_r <= 1'b0;
      sx_r <= '0; sx2_r <= '0; sx3_r <= '0; sx4_r <= '0;
      sy_r <= '0; sxy_r <= '0; sx2y_r <= '0;
    end else if (cmd.publish) begin
      cnt_r <= '0; ovf_r <= 1'b0; take1_r <= 1'b0; take2_r <= 1'b0;
      sx_r <= '0; sx2_r <= '0; sx3_r <= '0; sx4_r <= '0;
      sy_r <= '0; sxy_r <= '0; sx2y_r <= '0;
    end else begin
      if (cmd.accept) begin
        if (cnt_r < MAXC) cnt_r <= cnt_r + 1'b1;
        else              ovf_r <= 1'b1;
      end
      take1_r <= cmd.accept && (cnt_r < MAXC);
      take2_r <= take1_r;
      if (take1_r) begin
        sx_r  <= sx_r + SX_W'(x1_r);
        sy_r  <= sy_r + SY_W'(y1_r);
        sx2_r <= sx2_r + SX2_W'(x2_r);
        sxy_r <= sxy_r + SXY_W'(xy_r);
      end
      if (take2_r) begin
        sx3_r  <= sx3_r + SX3_W'(x3_r);
        sx4_r  <= sx4_r + SX4_W'(x4_r);
        sx2y_r <= sx2y_r + SX2Y_W'(x2y_r);
      end
    end
  end

  // Operand select for the multiplier
  logic signed [OPW-1:0] opnd;
  always_comb begin
    case (cmd.op_sel)
      OP_N:    opnd = OPW'($signed({1'b0, cnt_r}));
      OP_SX:   opnd = OPW'(sx_r);
      OP_SX2:  opnd = OPW'(sx2_r);
      OP_SX3:  opnd = OPW'(sx3_r);
      OP_SX4:  opnd = OPW'(sx4_r);
      OP_SY:   opnd = OPW'(sy_r);
      OP_SXY:  opnd = OPW'(sxy_r);
      OP_SX2Y: opnd = OPW'(sx2y_r);
      default: opnd = '0;
    endcase
  end

  // Shift-add multiplier, one operand bit per cycle, sign bit weighted negative
  logic signed [WB-1:0]  p_r, mc_r, tmp_r, acc_r;
  logic signed [OPW-1:0] mp_r;
  logic [MCNT_W-1:0]     mcnt_r;
  logic                  mul_busy_r, mul_fin_r, to_acc_r, neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_fin_r  <= 1'b0;
    end else if (cmd.mul_start) begin
      mul_busy_r <= 1'b1;
      mul_fin_r  <= 1'b0;
    end else if (mul_busy_r) begin
      if (mul_fin_r) begin
        mul_busy_r <= 1'b0;
        mul_fin_r  <= 1'b0;
      end else if (mcnt_r == MCNT_W'(OPW - 1)) begin
        mul_fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_p) p_r <= WB'(opnd);
    if (cmd.acc_clr) acc_r <= '0;
    if (cmd.mul_start) begin
      mc_r     <= p_r;
      mp_r     <= opnd;
      tmp_r    <= '0;
      mcnt_r   <= '0;
      to_acc_r <= cmd.mul_to_acc;
      neg_r    <= cmd.mul_neg;
    end else if (mul_busy_r && !mul_fin_r) begin
      if (mp_r[0]) begin
        tmp_r <= (mcnt_r == MCNT_W'(OPW - 1)) ? tmp_r - mc_r : tmp_r + mc_r;
      end
      mc_r   <= mc_r <<< 1;
      mp_r   <= mp_r >>> 1;
      mcnt_r <= mcnt_r + 1'b1;
    end else if (mul_busy_r && mul_fin_r) begin
      if (to_acc_r) acc_r <= neg_r ? acc_r - tmp_r : acc_r + tmp_r;
      else          p_r <= tmp_r;
    end
  end

  // Denominator magnitude and sign
  logic [WB-1:0] den_mag_r;
  logic          den_neg_r;
  always_ff @(posedge clk) begin
    if (cmd.save_den) begin
      den_neg_r <= acc_r[WB-1];
      den_mag_r <= acc_r[WB-1] ? WB'(-acc_r) : WB'(acc_r);
    end
  end

  // Restoring divider: round(num/den * 2^F) as (2|n|*2^F + |d|) / (2|d|)
  div_state_t        dstate_r;
  logic [WB-1:0]     nmag_r, quo_r, d2_r;
  logic [WB:0]       rem_r, rem_sh;
  logic [DCNT_W-1:0] dcnt_r;
  logic              qneg_r, ge;
  coef_sel_t         csel_r;
  logic [COEF_W-1:0] qval;
  logic              qsat;

  assign rem_sh = {rem_r[WB-1:0], quo_r[WB-1]};
  assign ge     = rem_sh >= {1'b0, d2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= DIV_IDLE;
    end else begin
      case (dstate_r)
        DIV_IDLE: if (cmd.div_start) dstate_r <= DIV_PREP;
        DIV_PREP: dstate_r <= DIV_ITER;
        DIV_ITER: if (dcnt_r == DCNT_W'(WB - 1)) dstate_r <= DIV_FIN;
        DIV_FIN:  dstate_r <= DIV_IDLE;
        default:  dstate_r <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (dstate_r)
      DIV_IDLE: begin
        if (cmd.div_start) begin
          nmag_r <= acc_r[WB-1] ? WB'(-acc_r) : WB'(acc_r);
          qneg_r <= acc_r[WB-1] ^ den_neg_r;
          csel_r <= cmd.coef_sel;
        end
      end
      DIV_PREP: begin
        quo_r  <= (nmag_r << (FRAC_BITS + 1)) + den_mag_r;
        d2_r   <= den_mag_r << 1;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      DIV_ITER: begin
        rem_r  <= ge ? rem_sh - {1'b0, d2_r} : rem_sh;
        quo_r  <= {quo_r[WB-2:0], ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Saturate quotient into signed 48 bits
  always_comb begin
    qsat = 1'b0;
    if (!qneg_r) begin
      if (quo_r > POS_LIM) begin qval = POS_COEF; qsat = 1'b1; end
      else                 qval = quo_r[COEF_W-1:0];
    end else begin
      if (quo_r > NEG_MAG) begin qval = NEG_COEF; qsat = 1'b1; end
      else                 qval = COEF_W'(-quo_r[COEF_W-1:0]);
    end
  end

  // Coefficient and flag registers for the current solve
  logic [COEF_W-1:0] cq_r, cl_r, cc_r;
  logic              sat_r, sing_r;
  always_ff @(posedge clk) begin
    if (cmd.coef_clr) begin
      cq_r <= '0; cl_r <= '0; cc_r <= '0; sat_r <= 1'b0; sing_r <= 1'b0;
    end else begin
      if (cmd.set_sing) sing_r <= 1'b1;
      if (dstate_r == DIV_FIN) begin
        if (qsat) sat_r <= 1'b1;
        case (csel_r)
          COEF_QUAD:  cq_r <= qval;
          COEF_LIN:   cl_r <= qval;
          COEF_CONST: cc_r <= qval;
          default:    cc_r <= qval;
        endcase
      end
    end
  end

  // Output register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.publish) out_valid_r <= 1'b1;
    else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_coef_quad   <= cq_r;
      out_coef_lin    <= cl_r;
      out_coef_const  <= cc_r;
      out_singular    <= sing_r;
      out_saturated   <= sat_r | ovf_r;
      out_points_used <= cnt_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.mul_busy = mul_busy_r;
  assign stat.div_busy = (dstate_r != DIV_IDLE);
  assign stat.acc_zero = (acc_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

>>> rtl/lspf_ctrl.sv
// Controller: degree register and the solve sequencer over determinant terms.
`default_nettype none
module lspf_ctrl (
  input  wire  logic                        clk,
  input  wire  logic                        rst_n,
  input  wire  logic                        in_valid,
  input  wire  logic                        in_last_point,
  output logic                              in_stall,
  input  wire  logic                        cfg_valid,
  input  wire  logic [lspf_pkg::DEG_W-1:0]  cfg_data,
  output lspf_pkg::dp_cmd_t                 cmd,
  input  wire  lspf_pkg::dp_stat_t          stat
);
  import lspf_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [DEG_W-1:0] deg_r;
  logic        quad;
  term_t       term;
  logic [2:0]  last_k;
  logic [1:0]  last_ph;

  assign quad    = (deg_r != DEG_LINE);
  assign term    = term_info(quad, ph_r, k_r);
  assign last_k  = quad ? 3'd5 : 3'd1;
  assign last_ph = quad ? 2'd3 : 2'd2;

  // Degree register, always ready
  always_ff @(posedge clk) begin
    if (!rst_n) deg_r <= 2'd2;
    else if (cfg_valid) deg_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      k_r     <= k_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE:   if (in_valid && in_last_point) state_nxt = ST_DRAIN0;
      ST_DRAIN0: state_nxt = ST_DRAIN1;
      ST_DRAIN1: state_nxt = ST_START;
      ST_START: begin
        ph_nxt    = '0;
        k_nxt     = '0;
        state_nxt = ST_LOADP;
      end
      ST_LOADP:  state_nxt = ST_MULA;
      ST_MULA:   state_nxt = ST_WAITA;
      ST_WAITA: begin
        if (!stat.mul_busy) state_nxt = term.three ? ST_MULB : ST_ENDTERM;
      end
      ST_MULB:   state_nxt = ST_WAITB;
      ST_WAITB:  if (!stat.mul_busy) state_nxt = ST_ENDTERM;
      ST_ENDTERM: begin
        if (k_r == last_k) begin
          k_nxt     = '0;
          state_nxt = (ph_r == 2'd0) ? ST_DENCHK : ST_DIVGO;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_LOADP;
        end
      end
      ST_DENCHK: begin
        if (stat.acc_zero) begin
          state_nxt = ST_PUB;
        end else begin
          ph_nxt    = 2'd1;
          state_nxt = ST_LOADP;
        end
      end
      ST_DIVGO:  state_nxt = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (!stat.div_busy) begin
          if (ph_r == last_ph) begin
            state_nxt = ST_PUB;
          end else begin
            ph_nxt    = ph_r + 1'b1;
            state_nxt = ST_LOADP;
          end
        end
      end
      ST_PUB:    if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.op_sel   = term.f1;
    cmd.coef_sel = coef_for(quad, ph_r);
    in_stall     = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:  cmd.accept = in_valid;
      ST_START: begin
        cmd.acc_clr  = 1'b1;
        cmd.coef_clr = 1'b1;
      end
      ST_LOADP: cmd.load_p = 1'b1;
      ST_MULA: begin
        cmd.mul_start  = 1'b1;
        cmd.op_sel     = term.f2;
        cmd.mul_to_acc = !term.three;
        cmd.mul_neg    = term.neg;
      end
      ST_MULB: begin
        cmd.mul_start  = 1'b1;
        cmd.op_sel     = term.f3;
        cmd.mul_to_acc = 1'b1;
        cmd.mul_neg    = term.neg;
      end
      ST_DENCHK: begin
        cmd.save_den = 1'b1;
        cmd.acc_clr  = 1'b1;
        cmd.set_sing = stat.acc_zero;
      end
      ST_DIVGO: begin
        cmd.div_start = 1'b1;
        cmd.acc_clr   = 1'b1;
      end
      ST_PUB:   cmd.publish = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/least_squares_polynomial_fit.sv
// Top level of the least squares line / parabola fit over a stream of points.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_x_coord, in_y_coord, in_last_point
//  out     | output    | out_valid/out_stall | coef_quad, coef_lin, coef_const, flags, count
//  cfg     | input     | cfg_valid/cfg_ready | cfg_data = fit degree
//
// Points are accumulated at one beat per cycle. A last point closes the set: the
// drain states ST_DRAIN0 and ST_DRAIN1, then the solve on the bit-serial multiplier
// and the one-bit-per-cycle divider. Input is stalled during the solve and while
// the result waits for the output register. Reset is synchronous and clears all
// sums.
`default_nettype none
module least_squares_polynomial_fit #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire  logic                                clk,
  input  wire  logic                                rst_n,
  input  wire  logic                                in_valid,
  output logic                                      in_stall,
  input  wire  logic signed [lspf_pkg::COORD_W-1:0] in_x_coord,
  input  wire  logic signed [lspf_pkg::COORD_W-1:0] in_y_coord,
  input  wire  logic                                in_last_point,
  output logic                                      out_valid,
  input  wire  logic                                out_stall,
  output logic signed [lspf_pkg::COEF_W-1:0]        out_coef_quad,
  output logic signed [lspf_pkg::COEF_W-1:0]        out_coef_lin,
  output logic signed [lspf_pkg::COEF_W-1:0]        out_coef_const,
  output logic                                      out_singular,
  output logic                                      out_saturated,
  output logic [lspf_pkg::CNT_W-1:0]                out_points_used,
  input  wire  logic                                cfg_valid,
  output logic                                      cfg_ready,
  input  wire  logic [lspf_pkg::DEG_W-1:0]          cfg_data
);
  import lspf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  lspf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .in_stall      (in_stall),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat)
  );

  lspf_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .cmd             (cmd),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_coef_quad   (out_coef_quad),
    .out_coef_lin    (out_coef_lin),
    .out_coef_const  (out_coef_const),
    .out_singular    (out_singular),
    .out_saturated   (out_saturated),
    .out_points_used (out_points_used)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_least_squares_polynomial_fit.sv
// Self-checking testbench for the least squares line / parabola fit block.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the point sums, predicts each fit and compares it with the block's beat
class fit_scoreboard;
  typedef logic signed [255:0] big_t;
  typedef logic [255:0] ubig_t;
  typedef struct {
    logic [47:0] quad;
    logic [47:0] lin;
    logic [47:0] cnst;
    logic        sing;
    logic        sat;
    logic [12:0] used;
  } fit_t;

  localparam int CAPACITY = 4096;
  localparam int FRAC     = 16;

  logic [1:0] degree;
  longint     n_pts, sx, sx2, sx3, sx4, sy, sxy, sx2y;
  bit         dropped;
  fit_t       pending_fits[$];
  int         errors, fits_checked, points_seen, singular_seen, sat_seen;

  function new();
    degree = 2'd2;
    clear_sums();
  endfunction

  function void clear_sums();
    n_pts = 0; sx = 0; sx2 = 0; sx3 = 0; sx4 = 0;
    sy = 0; sxy = 0; sx2y = 0; dropped = 0;
  endfunction

  function void set_degree(logic [1:0] d);
    degree = d;
  endfunction

  function big_t prod3(longint a, longint b, longint c);
    big_t wa, wb, wc;
    wa = a; wb = b; wc = c;
    return wa * wb * wc;
  endfunction

  function big_t det3(longint m[9]);
    big_t t;
    t = prod3(m[0], m[4], m[8]) - prod3(m[0], m[5], m[7]);
    t = t - prod3(m[1], m[3], m[8]) + prod3(m[1], m[5], m[6]);
    t = t + prod3(m[2], m[3], m[7]) - prod3(m[2], m[4], m[6]);
    return t;
  endfunction

  // round(num/den * 2^FRAC), ties away from zero, clamped to 48 bits
  function logic [47:0] fixed_quot(big_t num, big_t den, inout bit sat);
    bit    neg;
    ubig_t n, d, q;
    neg = (num < 0) ^ (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = ((n << (FRAC + 1)) + d) / (d << 1);
    if (!neg) begin
      if (q > 256'h7FFF_FFFF_FFFF) begin
        sat = 1;
        return 48'h7FFF_FFFF_FFFF;
      end
      return q[47:0];
    end
    if (q > 256'h8000_0000_0000) begin
      sat = 1;
      return 48'h8000_0000_0000;
    end
    return -q[47:0];
  endfunction

  // Accepted input beat: accumulate, and on the last point predict the fit
  function void note_point(logic signed [11:0] xc, logic signed [11:0] yc, logic last);
    longint x, y, x2;
    big_t   den, nk, nb;
    longint m[9], t[9], rhs[3];
    logic [47:0] res[3];
    bit     sat;
    fit_t   f;
    x = xc; y = yc;
    points_seen++;
    if (n_pts < CAPACITY) begin
      x2 = x * x;
      n_pts++;
      sx += x; sx2 += x2; sx3 += x2 * x; sx4 += x2 * x2;
      sy += y; sxy += x * y; sx2y += x2 * y;
    end else begin
      dropped = 1;
    end
    if (!last) return;
    sat = 0;
    f.quad = '0; f.lin = '0; f.cnst = '0; f.sing = 0;
    if (degree == 2'd1) begin
      den = big_t'(sx2) * big_t'(n_pts) - big_t'(sx) * big_t'(sx);
      if (den == 0) begin
        f.sing = 1;
      end else begin
        nk = big_t'(sxy) * big_t'(n_pts) - big_t'(sx) * big_t'(sy);
        nb = big_t'(sx2) * big_t'(sy) - big_t'(sx) * big_t'(sxy);
        f.lin  = fixed_quot(nk, den, sat);
        f.cnst = fixed_quot(nb, den, sat);
      end
    end else begin
      m = '{n_pts, sx, sx2, sx, sx2, sx3, sx2, sx3, sx4};
      rhs = '{sy, sxy, sx2y};
      den = det3(m);
      if (den == 0) begin
        f.sing = 1;
      end else begin
        for (int c = 0; c < 3; c++) begin
          t = m;
          for (int r = 0; r < 3; r++) t[r * 3 + c] = rhs[r];
          res[c] = fixed_quot(det3(t), den, sat);
        end
        f.cnst = res[0]; f.lin = res[1]; f.quad = res[2];
      end
    end
    f.sat  = sat | dropped;
    f.used = n_pts[12:0];
    pending_fits = {pending_fits, f};
    clear_sums();
  endfunction

  // Result beat: compare against the oldest predicted fit
  function void check_result(logic [47:0] q, logic [47:0] l, logic [47:0] c,
                             logic sing, logic sat, logic [12:0] used);
    fit_t f;
    if (pending_fits.size() == 0) begin
      $display("%0t: unexpected result beat q=%h l=%h c=%h", $time, q, l, c);
      errors++;
      return;
    end
    f = pending_fits.pop_front();
    fits_checked++;
    if (f.sing) singular_seen++;
    if (f.sat) sat_seen++;
    if (q !== f.quad) begin
      $display("%0t: coef_quad exp %h got %h", $time, f.quad, q); errors++;
    end
    if (l !== f.lin) begin
      $display("%0t: coef_lin exp %h got %h", $time, f.lin, l); errors++;
    end
    if (c !== f.cnst) begin
      $display("%0t: coef_const exp %h got %h", $time, f.cnst, c); errors++;
    end
    if (sing !== f.sing) begin
      $display("%0t: singular exp %b got %b", $time, f.sing, sing); errors++;
    end
    if (sat !== f.sat) begin
      $display("%0t: saturated exp %b got %b", $time, f.sat, sat); errors++;
    end
    if (used !== f.used) begin
      $display("%0t: points_used exp %0d got %0d", $time, f.used, used); errors++;
    end
  endfunction
endclass

module tb_least_squares_polynomial_fit;
  import lspf_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, in_last_point;
  logic signed [COORD_W-1:0] in_x_coord, in_y_coord;
  logic out_valid, out_stall, out_singular, out_saturated;
  logic signed [COEF_W-1:0] out_coef_quad, out_coef_lin, out_coef_const;
  logic [CNT_W-1:0] out_points_used;
  logic cfg_valid, cfg_ready;
  logic [DEG_W-1:0] cfg_data;

  fit_scoreboard sb = new();
  int send_idle_pct, recv_idle_pct;
  int items_sent, cfg_writes;

  least_squares_polynomial_fit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_coef_quad(out_coef_quad), .out_coef_lin(out_coef_lin),
    .out_coef_const(out_coef_const), .out_singular(out_singular),
    .out_saturated(out_saturated), .out_points_used(out_points_used),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Input and output beat monitors, sampling pre-edge values
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_point(in_x_coord, in_y_coord, in_last_point);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_coef_quad, out_coef_lin, out_coef_const,
                      out_singular, out_saturated, out_points_used);
  end

  // One point beat, with an optional random gap ahead of it
  task automatic send_point(logic signed [11:0] x, logic signed [11:0] y, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_x_coord    <= x;
    in_y_coord    <= y;
    in_last_point <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Degree write, only once all fits are out and the block has settled
  task automatic write_degree(logic [1:0] d);
    go_idle();
    while (sb.pending_fits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    sb.set_degree(d);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // A set of random points; narrow x spread makes degenerate fits likely
  task automatic send_set(int len);
    int spread;
    spread = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      logic signed [11:0] x;
      case (spread)
        0: x = 12'($urandom_range(1));
        1: x = 12'($urandom_range(7) - 4);
        default: x = 12'($urandom);
      endcase
      send_point(x, 12'($urandom), i == len - 1);
    end
  endtask

  initial begin
    int n;
    rst_n = 0; in_valid = 0; in_x_coord = '0; in_y_coord = '0; in_last_point = 0;
    out_stall = 0; cfg_valid = 0; cfg_data = '0;
    send_idle_pct = 18; recv_idle_pct = 81;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset degree, single point (singular), extremes, exact parabola
    send_point(12'sd5, 12'sd7, 1'b1);
    send_point(-12'sd2048, -12'sd2048, 1'b0);
    send_point(12'sd2047, 12'sd2047, 1'b0);
    send_point(12'sd0, -12'sd2048, 1'b1);
    send_point(12'sd1, 12'sd1, 1'b0);
    send_point(12'sd1, 12'sd3, 1'b0);
    send_point(12'sd2, 12'sd4, 1'b1);
    send_point(-12'sd1, 12'sd1, 1'b0);
    send_point(12'sd0, 12'sd0, 1'b0);
    send_point(12'sd1, 12'sd1, 1'b0);
    send_point(12'sd2, 12'sd4, 1'b1);
    write_degree(2'd1);
    send_point(12'sd3, 12'sd9, 1'b1);
    send_point(-12'sd2048, 12'sd2047, 1'b0);
    send_point(12'sd2047, -12'sd2048, 1'b1);
    send_point(12'sd0, 12'sd1, 1'b0);
    send_point(12'sd1, 12'sd2, 1'b0);
    send_point(12'sd2, 12'sd4, 1'b1);
    write_degree(2'd0);
    send_point(12'sd1, 12'sd1, 1'b0);
    send_point(12'sd2, 12'sd2, 1'b0);
    send_point(12'sd3, 12'sd5, 1'b1);
    write_degree(2'd3);
    send_point(12'sd4, 12'sd1, 1'b0);
    send_point(12'sd4, 12'sd2, 1'b1);

    // Random sets, idling profile changing by thirds
    while (items_sent < 925) begin
      if (items_sent > 630) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else if (items_sent > 310) begin
        send_idle_pct = 81; recv_idle_pct = 18;
      end
      if ($urandom_range(99) < 30) write_degree(2'($urandom_range(3)));
      n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
      send_set(n);
    end

    // Drain
    go_idle();
    n = 0;
    while (sb.pending_fits.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (50) @(posedge clk);
    $display("Sent %0d points in %0d fits, %0d degree writes.",
             items_sent, sb.fits_checked, cfg_writes);
    $display("Fits with singular flag: %0d, with saturated flag: %0d.",
             sb.singular_seen, sb.sat_seen);
    if (sb.errors == 0 && sb.pending_fits.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
